// ===== design/gcd_pkg.sv =====
// Shared constants and types for the great-circle distance pipeline.
package gcd_pkg;

    localparam int TERMS     = 14;
    localparam int TAY_LAT   = 2 * TERMS + 2;
    localparam int RAD_LAT   = 3;
    localparam int BIS_STEPS = 32;

    localparam logic [31:0] ONE_Q30    = 32'd1073741824;
    localparam logic [31:0] HALF_Q30   = 32'd536870912;
    localparam logic [31:0] PI_Q30     = 32'd3373259426;
    localparam logic [31:0] HALFPI_Q30 = 32'd1686629713;
    localparam logic signed [31:0] POS_ONE = 32'sd1073741824;
    localparam logic signed [31:0] NEG_ONE = -32'sd1073741824;

    localparam logic signed [23:0] LAT_MAX   = 24'sd5898240;
    localparam logic signed [24:0] LON_MAX   = 25'sd11796480;
    localparam logic [25:0]        FULL_TURN = 26'd23592960;

    // degrees Q16 -> radians Q30: (m * RAD_NUM + RAD_HALF) / RAD_DEN
    localparam logic [30:0] RAD_NUM  = 31'd1638400000;
    localparam logic [22:0] RAD_DEN  = 23'd5729578;
    localparam logic [22:0] RAD_HALF = 23'd2864789;
    localparam int          RAD_SH   = 24;
    localparam logic [63:0] RAD_RECIP_W = (64'd1638400000 << RAD_SH) / 64'd5729578;
    localparam logic [32:0] RAD_RECIP   = RAD_RECIP_W[32:0];
    localparam logic [63:0] RAD_OFS_W   = (64'd2864789 << RAD_SH) / 64'd5729578;
    localparam logic [23:0] RAD_OFS     = RAD_OFS_W[23:0];

    localparam logic [22:0] EARTH_M = 23'd6371000;

    typedef struct packed {
        logic [31:0]        lo;
        logic [31:0]        hi;
        logic signed [31:0] c;
    } bis_t;

endpackage

// ===== design/gcd_rad.sv =====
// Degrees-to-radians converter: reciprocal estimate plus one remainder correction.
module gcd_rad (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_vld,
    input  logic [23:0] mag,
    output logic        out_vld,
    output logic [31:0] rad
);
    import gcd_pkg::*;

    logic        v1_reg, v2_reg, v3_reg;
    logic [23:0] m1_reg;
    logic [56:0] p1_reg;
    logic [55:0] num2_reg;
    logic [55:0] qd2_reg;
    logic [31:0] est2_reg;
    logic [31:0] rad3_reg;
    logic [55:0] rem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign rem = num2_reg - qd2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            // estimate never exceeds the true quotient, and is short by at most one
            m1_reg   <= mag;
            p1_reg   <= 57'(mag) * 57'(RAD_RECIP) + 57'(RAD_OFS);
            est2_reg <= p1_reg[55:24];
            num2_reg <= 56'(m1_reg) * 56'(RAD_NUM) + 56'(RAD_HALF);
            qd2_reg  <= 56'(p1_reg[55:24]) * 56'(RAD_DEN);
            rad3_reg <= est2_reg + ((rem >= 56'(RAD_DEN)) ? 32'd1 : 32'd0);
        end
    end

    assign out_vld = v3_reg;
    assign rad     = rad3_reg;

endmodule

// ===== design/gcd_taylor.sv =====
// Pipelined 15-term Taylor series for sine or cosine on [0, pi/2], Q30.
module gcd_taylor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_vld,
    input  logic        odd,
    input  logic [30:0] x,
    output logic        out_vld,
    output logic [30:0] val
);
    import gcd_pkg::*;

    logic        vsq_reg;
    logic [61:0] xsq_reg;
    logic [31:0] t0_reg;

    logic               c_vld  [TERMS+1];
    logic [31:0]        c_term [TERMS+1];
    logic signed [33:0] c_sum  [TERMS+1];
    logic [31:0]        c_x2   [TERMS+1];

    logic               va_reg  [TERMS];
    logic [63:0]        pa_reg  [TERMS];
    logic [31:0]        x2a_reg [TERMS];
    logic signed [33:0] sa_reg  [TERMS];
    logic               vb_reg  [TERMS];
    logic [64:0]        qb_reg  [TERMS];
    logic [31:0]        x2b_reg [TERMS];
    logic signed [33:0] sb_reg  [TERMS];

    logic        vo_reg;
    logic [30:0] val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vsq_reg <= 1'b0;
        else if (en)  vsq_reg <= in_vld;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xsq_reg <= 62'(x) * 62'(x);
            t0_reg  <= odd ? {1'b0, x} : ONE_Q30;
        end
    end

    assign c_vld[0]  = vsq_reg;
    assign c_term[0] = t0_reg;
    assign c_sum[0]  = $signed({2'b00, t0_reg});
    assign c_x2[0]   = xsq_reg[61:30];

    for (genvar k = 0; k < TERMS; k++) begin : g_term
        localparam int DC = (2 * k + 1) * (2 * k + 2);
        localparam int DS = (2 * k + 2) * (2 * k + 3);
        localparam int LC = $clog2(DC);
        localparam int LS = $clog2(DS);
        localparam logic [63:0] MCW = ((64'd1 << (32 + LC)) / 64'(DC)) + 64'd1;
        localparam logic [63:0] MSW = ((64'd1 << (32 + LS)) / 64'(DS)) + 64'd1;

        logic [32:0] mk;
        logic [31:0] nk;
        logic [31:0] term;

        assign mk = odd ? MSW[32:0] : MCW[32:0];
        assign nk = pa_reg[k][61:30];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                va_reg[k] <= 1'b0;
                vb_reg[k] <= 1'b0;
            end else if (en) begin
                va_reg[k] <= c_vld[k];
                vb_reg[k] <= va_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                pa_reg[k]  <= 64'(c_term[k]) * 64'(c_x2[k]);
                x2a_reg[k] <= c_x2[k];
                sa_reg[k]  <= c_sum[k];
                // exact floor division by a constant: multiply and shift
                qb_reg[k]  <= 65'(nk) * 65'(mk);
                x2b_reg[k] <= x2a_reg[k];
                sb_reg[k]  <= sa_reg[k];
            end
        end

        assign term = odd ? 32'(qb_reg[k] >> (32 + LS)) : 32'(qb_reg[k] >> (32 + LC));

        assign c_vld[k+1]  = vb_reg[k];
        assign c_term[k+1] = term;
        assign c_x2[k+1]   = x2b_reg[k];
        assign c_sum[k+1]  = ((k % 2) == 0) ? sb_reg[k] - $signed({2'b00, term})
                                            : sb_reg[k] + $signed({2'b00, term});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vo_reg <= 1'b0;
        else if (en)  vo_reg <= c_vld[TERMS];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (c_sum[TERMS] < 0)
                val_reg <= '0;
            else if (c_sum[TERMS] > $signed({2'b00, ONE_Q30}))
                val_reg <= ONE_Q30[30:0];
            else
                val_reg <= c_sum[TERMS][30:0];
        end
    end

    assign out_vld = vo_reg;
    assign val     = val_reg;

endmodule

// ===== design/gcd_bis_step.sv =====
// One arccosine bisection step: half-turn cosine of the midpoint, then interval update.
module gcd_bis_step (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_vld,
    input  gcd_pkg::bis_t in_st,
    output logic          out_vld,
    output gcd_pkg::bis_t out_st
);
    import gcd_pkg::*;

    typedef struct packed {
        bis_t        st;
        logic [31:0] mid;
        logic        neg;
        logic        m1;
    } side_t;

    logic [31:0] mid;
    logic        p_vld_reg;
    logic [30:0] p_arg_reg;
    side_t       p_side_reg;
    side_t       sd_reg [TAY_LAT];
    logic        t_vld;
    logic [30:0] t_val;
    logic signed [31:0] cosv;
    side_t       s_end;
    logic        o_vld_reg;
    bis_t        o_st_reg;
    bis_t        st_next;

    assign mid = 32'((33'(in_st.lo) + 33'(in_st.hi)) >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) p_vld_reg <= 1'b0;
        else if (en)  p_vld_reg <= in_vld;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_side_reg.st  <= in_st;
            p_side_reg.mid <= mid;
            p_side_reg.neg <= (mid > HALFPI_Q30);
            p_side_reg.m1  <= (mid >= PI_Q30);
            p_arg_reg      <= (mid > HALFPI_Q30) ? 31'(PI_Q30 - mid) : mid[30:0];
        end
    end

    gcd_taylor u_cos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (p_vld_reg),
        .odd     (1'b0),
        .x       (p_arg_reg),
        .out_vld (t_vld),
        .val     (t_val)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0] <= p_side_reg;
            for (int i = 1; i < TAY_LAT; i++) sd_reg[i] <= sd_reg[i-1];
        end
    end

    assign s_end = sd_reg[TAY_LAT-1];

    always_comb begin
        if (s_end.m1)       cosv = NEG_ONE;
        else if (s_end.neg) cosv = -$signed({1'b0, t_val});
        else                cosv = $signed({1'b0, t_val});
        st_next = s_end.st;
        if (cosv > s_end.st.c) st_next.lo = s_end.mid;
        else                   st_next.hi = s_end.mid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) o_vld_reg <= 1'b0;
        else if (en)  o_vld_reg <= t_vld;
    end

    always_ff @(posedge aclk) begin
        if (en) o_st_reg <= st_next;
    end

    assign out_vld = o_vld_reg;
    assign out_st  = o_st_reg;

endmodule

// ===== design/great_circle_distance_core.sv =====
// Top level: great-circle distance by the spherical law of cosines, fully pipelined.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_lat_a s_lon_a ...     | in
//  result  | m_valid m_ready m_distance_m            | out
//
// One transaction per cycle in, one out, while the result is not stalled; most of the
// depth is the arccosine: 32 bisection steps, each with a 30-stage Taylor cosine.
// aresetn is synchronous, active low, and clears only the valid bits.
// A stalled result freezes the whole pipeline (s_ready follows it); bubbles
// inside still travel while the output register is empty.
module great_circle_distance_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [23:0] s_lat_a,
    input  logic signed [24:0] s_lon_a,
    input  logic signed [23:0] s_lat_b,
    input  logic signed [24:0] s_lon_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [24:0]        m_distance_m
);
    import gcd_pkg::*;

    function automatic logic signed [24:0] clamp25(input logic signed [24:0] v,
                                                   input logic signed [24:0] lim);
        if (v > lim)       return lim;
        else if (v < -lim) return -lim;
        else               return v;
    endfunction

    logic en;

    // front end: clamp, magnitudes, longitude difference fold
    logic               f1_vld_reg, f2_vld_reg, f3_vld_reg;
    logic signed [23:0] f1_la_reg, f1_lb_reg;
    logic signed [24:0] f1_oa_reg, f1_ob_reg;
    logic [23:0]        f2_ma_reg, f2_mb_reg;
    logic               f2_sa_reg, f2_sb_reg;
    logic signed [25:0] f2_d_reg;
    logic [23:0]        f3_ma_reg, f3_mb_reg, f3_md_reg;
    logic [1:0]         f3_sg_reg;
    logic [25:0]        dabs;

    // radians
    logic        ra_vld;
    logic [31:0] ra, rb, rd;
    logic [1:0]  rsg_reg [RAD_LAT];

    // trig inputs
    logic        t0_vld_reg;
    logic [30:0] t0_xa_reg, t0_xb_reg, t0_xd_reg;
    logic [3:0]  t0_fl_reg;
    logic        tr_vld;
    logic [30:0] sin_a, cos_a, sin_b, cos_b, cos_d;
    logic [3:0]  tsd_reg [TAY_LAT];
    logic [3:0]  tfl;

    // product and sum
    logic        m1_vld_reg, m2_vld_reg, m3_vld_reg;
    logic [62:0] ss_full, cc_full, cp_full;
    logic [30:0] m1_ss_reg, m1_cc_reg, m1_cd_reg;
    logic        m1_sneg_reg, m1_cneg_reg;
    logic [30:0] m2_ss_reg, m2_cp_reg;
    logic        m2_sneg_reg, m2_cneg_reg;
    logic signed [32:0] csum;
    logic signed [31:0] m3_c_reg;

    // bisection chain
    logic bis_vld [BIS_STEPS+1];
    bis_t bis_st  [BIS_STEPS+1];

    logic        o_vld_reg;
    logic [24:0] o_dist_reg;
    logic [63:0] dist_full;

    assign en      = !o_vld_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
            t0_vld_reg <= 1'b0;
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
        end else if (en) begin
            f1_vld_reg <= s_valid;
            f2_vld_reg <= f1_vld_reg;
            f3_vld_reg <= f2_vld_reg;
            t0_vld_reg <= ra_vld;
            m1_vld_reg <= tr_vld;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
            o_vld_reg  <= bis_vld[BIS_STEPS];
        end
    end

    assign dabs = f2_d_reg[25] ? 26'(-f2_d_reg) : 26'(f2_d_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_la_reg <= 24'(clamp25(25'(s_lat_a), 25'(LAT_MAX)));
            f1_lb_reg <= 24'(clamp25(25'(s_lat_b), 25'(LAT_MAX)));
            f1_oa_reg <= clamp25(s_lon_a, LON_MAX);
            f1_ob_reg <= clamp25(s_lon_b, LON_MAX);

            f2_sa_reg <= f1_la_reg[23];
            f2_sb_reg <= f1_lb_reg[23];
            f2_ma_reg <= f1_la_reg[23] ? 24'(-f1_la_reg) : 24'(f1_la_reg);
            f2_mb_reg <= f1_lb_reg[23] ? 24'(-f1_lb_reg) : 24'(f1_lb_reg);
            f2_d_reg  <= 26'(f1_ob_reg) - 26'(f1_oa_reg);

            // past half a turn, go the short way round
            f3_md_reg <= (dabs > 26'(LON_MAX)) ? 24'(FULL_TURN - dabs) : dabs[23:0];
            f3_ma_reg <= f2_ma_reg;
            f3_mb_reg <= f2_mb_reg;
            f3_sg_reg <= {f2_sb_reg, f2_sa_reg};
        end
    end

    gcd_rad u_rad_a (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_vld (f3_vld_reg), .mag (f3_ma_reg), .out_vld (ra_vld), .rad (ra)
    );
    gcd_rad u_rad_b (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_vld (f3_vld_reg), .mag (f3_mb_reg), .out_vld (), .rad (rb)
    );
    gcd_rad u_rad_d (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_vld (f3_vld_reg), .mag (f3_md_reg), .out_vld (), .rad (rd)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            rsg_reg[0] <= f3_sg_reg;
            for (int i = 1; i < RAD_LAT; i++) rsg_reg[i] <= rsg_reg[i-1];
        end
    end

    // flags: {cos_d is -1, cos_d negative, lat_b negative, lat_a negative}
    always_ff @(posedge aclk) begin
        if (en) begin
            t0_xa_reg <= ra[30:0];
            t0_xb_reg <= rb[30:0];
            t0_xd_reg <= (rd > HALFPI_Q30) ? 31'(PI_Q30 - rd) : rd[30:0];
            t0_fl_reg <= {(rd >= PI_Q30), (rd > HALFPI_Q30), rsg_reg[RAD_LAT-1]};
        end
    end

    gcd_taylor u_sin_a (
        .aclk (aclk), .aresetn (aresetn), .en (en), .in_vld (t0_vld_reg),
        .odd (1'b1), .x (t0_xa_reg), .out_vld (tr_vld), .val (sin_a)
    );
    gcd_taylor u_cos_a (
        .aclk (aclk), .aresetn (aresetn), .en (en), .in_vld (t0_vld_reg),
        .odd (1'b0), .x (t0_xa_reg), .out_vld (), .val (cos_a)
    );
    gcd_taylor u_sin_b (
        .aclk (aclk), .aresetn (aresetn), .en (en), .in_vld (t0_vld_reg),
        .odd (1'b1), .x (t0_xb_reg), .out_vld (), .val (sin_b)
    );
    gcd_taylor u_cos_b (
        .aclk (aclk), .aresetn (aresetn), .en (en), .in_vld (t0_vld_reg),
        .odd (1'b0), .x (t0_xb_reg), .out_vld (), .val (cos_b)
    );
    gcd_taylor u_cos_d (
        .aclk (aclk), .aresetn (aresetn), .en (en), .in_vld (t0_vld_reg),
        .odd (1'b0), .x (t0_xd_reg), .out_vld (), .val (cos_d)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            tsd_reg[0] <= t0_fl_reg;
            for (int i = 1; i < TAY_LAT; i++) tsd_reg[i] <= tsd_reg[i-1];
        end
    end

    assign tfl = tsd_reg[TAY_LAT-1];

    // Q30 products on magnitudes, rounded half up, sign applied later
    assign ss_full = 63'(sin_a) * 63'(sin_b) + 63'(HALF_Q30);
    assign cc_full = 63'(cos_a) * 63'(cos_b) + 63'(HALF_Q30);
    assign cp_full = 63'(m1_cc_reg) * 63'(m1_cd_reg) + 63'(HALF_Q30);

    assign csum = (m2_sneg_reg ? -$signed({2'b00, m2_ss_reg}) : $signed({2'b00, m2_ss_reg}))
                + (m2_cneg_reg ? -$signed({2'b00, m2_cp_reg}) : $signed({2'b00, m2_cp_reg}));

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_ss_reg   <= ss_full[60:30];
            m1_cc_reg   <= cc_full[60:30];
            m1_cd_reg   <= tfl[3] ? ONE_Q30[30:0] : cos_d;
            m1_sneg_reg <= tfl[0] ^ tfl[1];
            m1_cneg_reg <= tfl[2] | tfl[3];

            m2_ss_reg   <= m1_ss_reg;
            m2_sneg_reg <= m1_sneg_reg;
            m2_cp_reg   <= cp_full[60:30];
            m2_cneg_reg <= m1_cneg_reg;

            if (csum > 33'(POS_ONE))      m3_c_reg <= POS_ONE;
            else if (csum < 33'(NEG_ONE)) m3_c_reg <= NEG_ONE;
            else                          m3_c_reg <= 32'(csum);
        end
    end

    // arccosine: bisection on [0, pi], keeps the lower bound
    assign bis_vld[0]   = m3_vld_reg;
    assign bis_st[0].lo = '0;
    assign bis_st[0].hi = PI_Q30;
    assign bis_st[0].c  = m3_c_reg;

    for (genvar s = 0; s < BIS_STEPS; s++) begin : g_bis
        gcd_bis_step u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_vld  (bis_vld[s]),
            .in_st   (bis_st[s]),
            .out_vld (bis_vld[s+1]),
            .out_st  (bis_st[s+1])
        );
    end

    assign dist_full = 64'(bis_st[BIS_STEPS].lo) * 64'(EARTH_M) + 64'(HALF_Q30);

    always_ff @(posedge aclk) begin
        if (en) o_dist_reg <= dist_full[54:30];
    end

    assign m_valid      = o_vld_reg;
    assign m_distance_m = o_dist_reg;

endmodule

// ===== sim/great_circle_distance_core_tb.sv =====
// Testbench for great_circle_distance_core: scoreboard with a fixed-point distance predictor.
`timescale 1ns / 100ps

// Scoreboard: predicts each accepted transaction's distance, then checks
// results in order against the oldest prediction.
class gcd_scoreboard;
    typedef longint unsigned u64_t;

    bit [24:0] dist_q[$];
    int        fail_cnt;
    int        mismatch_cnt;

    function new();
        fail_cnt     = 0;
        mismatch_cnt = 0;
    endfunction

    // Degrees Q16 magnitude to radians Q30, rounded to nearest.
    function u64_t to_rad(u64_t m);
        return (m * 64'd1638400000 + 64'd2864789) / 64'd5729578;
    endfunction

    // 15-term Taylor series on [0, pi/2]; odd selects sine.
    function longint series(u64_t x, bit odd);
        u64_t   x2, term, n;
        longint acc;
        x2   = (x * x) >> 30;
        term = odd ? x : 64'd1073741824;
        acc  = longint'(term);
        n    = odd ? 2 : 1;
        for (int k = 1; k <= 14; k++) begin
            term = ((term * x2) >> 30) / (n * (n + 1));
            n += 2;
            if (k & 1) acc -= longint'(term);
            else       acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > 64'sd1073741824) acc = 64'sd1073741824;
        return acc;
    endfunction

    // Cosine on [0, pi]; anything past pi reads as -1.
    function longint cos_to_pi(u64_t t);
        if (t <= 64'd1686629713) return series(t, 1'b0);
        if (t >= 64'd3373259426) return -64'sd1073741824;
        return -series(64'd3373259426 - t, 1'b0);
    endfunction

    // Q30 product on magnitudes, rounded half away from zero.
    function longint q30_mul(longint a, longint b);
        u64_t ua, ub, p;
        ua = (a < 0) ? u64_t'(-a) : u64_t'(a);
        ub = (b < 0) ? u64_t'(-b) : u64_t'(b);
        p  = (ua * ub + 64'd536870912) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function longint clip(longint v, longint lim);
        if (v > lim)  return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function bit [24:0] distance(logic signed [23:0] lat_a, logic signed [24:0] lon_a,
                                 logic signed [23:0] lat_b, logic signed [24:0] lon_b);
        longint la, oa, lb, ob, sa, ca, sb, cb, cd, c, d;
        u64_t   ra, rb, lo, hi, mid, dist_m;
        la = clip(longint'(lat_a), 5898240);
        oa = clip(longint'(lon_a), 11796480);
        lb = clip(longint'(lat_b), 5898240);
        ob = clip(longint'(lon_b), 11796480);
        ra = to_rad(u64_t'(la < 0 ? -la : la));
        rb = to_rad(u64_t'(lb < 0 ? -lb : lb));
        sa = series(ra, 1'b1);
        if (la < 0) sa = -sa;
        ca = series(ra, 1'b0);
        sb = series(rb, 1'b1);
        if (lb < 0) sb = -sb;
        cb = series(rb, 1'b0);
        d = ob - oa;
        if (d < 0) d = -d;
        if (d > 11796480) d = 23592960 - d;   // wrap across the date line
        cd = cos_to_pi(to_rad(u64_t'(d)));
        c  = clip(q30_mul(sa, sb) + q30_mul(q30_mul(ca, cb), cd), 64'sd1073741824);
        lo = 0;
        hi = 64'd3373259426;
        for (int i = 0; i < 32; i++) begin
            mid = (lo + hi) >> 1;
            if (cos_to_pi(mid) > c) lo = mid;
            else hi = mid;
        end
        dist_m = (lo * 64'd6371000 + 64'd536870912) >> 30;
        return dist_m[24:0];
    endfunction

    function void note_input(logic signed [23:0] lat_a, logic signed [24:0] lon_a,
                             logic signed [23:0] lat_b, logic signed [24:0] lon_b);
        dist_q.push_back(distance(lat_a, lon_a, lat_b, lon_b));
    endfunction

    function void check_result(bit [24:0] got);
        bit [24:0] want;
        if (dist_q.size() == 0) begin
            fail_cnt++;
            mismatch_cnt++;
            if (mismatch_cnt <= 10) $display("unexpected result distance_m=%0d", got);
            return;
        end
        want = dist_q.pop_front();
        if (got !== want) begin
            fail_cnt++;
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("distance_m mismatch: expected %0d, got %0d", want, got);
        end
    endfunction
endclass

module great_circle_distance_core_tb;
    localparam int LAT_LIM = 5898240;     // 90 degrees, Q16
    localparam int LON_LIM = 11796480;    // 180 degrees, Q16
    localparam int DEG     = 65536;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [23:0] s_lat_a = '0;
    logic signed [24:0] s_lon_a = '0;
    logic signed [23:0] s_lat_b = '0;
    logic signed [24:0] s_lon_b = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [24:0]        m_distance_m;

    gcd_scoreboard sb = new();

    int send_idle_pct = 0;   // chance per cycle that the sender sits out
    int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
    int hold_request = 0;    // long receiver hold-off, picked up by the receiver
    bit running = 1'b0;

    great_circle_distance_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_lat_a(s_lat_a), .s_lon_a(s_lon_a), .s_lat_b(s_lat_b), .s_lon_b(s_lon_b),
        .m_valid(m_valid), .m_ready(m_ready), .m_distance_m(m_distance_m)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver: random stalls plus an occasional long hold-off it counts itself.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (!running) m_ready = 1'b0;
            else if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else m_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Result monitor: every accepted transaction goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_distance_m);
    end

    // Offer one transaction; valid stays up until the handshake completes.
    task automatic send_point_pair(int lat_a, int lon_a, int lat_b, int lon_b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_lat_a = lat_a[23:0];
        s_lon_a = lon_a[24:0];
        s_lat_b = lat_b[23:0];
        s_lon_b = lon_b[24:0];
        do @(posedge aclk); while (!s_ready);
        sb.note_input(s_lat_a, s_lon_a, s_lat_b, s_lon_b);
        @(negedge aclk);
    endtask

    function automatic int rand_span(int lim);
        return $urandom_range(0, 2 * lim) - lim;
    endfunction

    // Mostly in-range points; some raw bit patterns, near-equal and near-antipodal pairs, and poles.
    task automatic send_random_pair();
        int kind, la, oa, lb, ob;
        kind = $urandom_range(0, 99);
        la = rand_span(LAT_LIM);
        oa = rand_span(LON_LIM);
        lb = rand_span(LAT_LIM);
        ob = rand_span(LON_LIM);
        if (kind < 15) begin
            la = $urandom();
            oa = $urandom();
            lb = $urandom();
            ob = $urandom();
        end else if (kind < 27) begin
            lb = la + $urandom_range(0, 200) - 100;
            ob = oa + $urandom_range(0, 200) - 100;
        end else if (kind < 39) begin
            lb = -la + $urandom_range(0, 200) - 100;
            ob = (oa > 0 ? oa - LON_LIM : oa + LON_LIM) + $urandom_range(0, 200) - 100;
        end else if (kind < 45) begin
            la = ($urandom_range(0, 1) ? LAT_LIM : -LAT_LIM);
        end
        send_point_pair(la, oa, lb, ob);
    endtask

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        running = 1'b1;

        // Directed: zero distance, poles, antipodes, date-line wrap, clamping.
        send_point_pair(0, 0, 0, 0);
        send_point_pair(LAT_LIM, 0, -LAT_LIM, 0);
        send_point_pair(LAT_LIM, LON_LIM, LAT_LIM, -LON_LIM);
        send_point_pair(0, 0, 0, LON_LIM);
        send_point_pair(0, -LON_LIM, 0, LON_LIM);
        send_point_pair(0, LON_LIM, 0, -LON_LIM);
        send_point_pair(0, 170 * DEG, 0, -170 * DEG);
        send_point_pair(0, 0, 0, 90 * DEG);
        send_point_pair(45 * DEG, 10 * DEG, -45 * DEG, -170 * DEG);
        send_point_pair(-LAT_LIM, -LON_LIM, LAT_LIM, LON_LIM);
        send_point_pair(-(1 << 23), -(1 << 24), (1 << 23) - 1, (1 << 24) - 1);
        send_point_pair((1 << 23) - 1, (1 << 24) - 1, -(1 << 23), -(1 << 24));
        send_point_pair(LAT_LIM + 1, LON_LIM + 1, -LAT_LIM - 1, -LON_LIM - 1);
        send_point_pair(1, 0, 0, 0);
        send_point_pair(0, 0, 0, 1);
        send_point_pair(30 * DEG, 20 * DEG, 30 * DEG, 20 * DEG + 1);
        send_point_pair(10 * DEG, 0, -10 * DEG, LON_LIM - 1);
        send_point_pair(-1, -1, 1, 1);
        send_point_pair(89 * DEG, 0, -89 * DEG, LON_LIM);

        // Random phases: free flow, idle sender, stalling receiver, both.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 61 : (phase == 3) ? 21 : 0;
            recv_stall_pct = (phase == 2) ? 61 : (phase == 3) ? 21 : 0;
            for (int n = 0; n < 358; n++) begin
                if (phase == 0 && n == 40) hold_request = 3000;  // fill the pipe
                send_random_pair();
            end
        end
        s_valid = 1'b0;

        while (sb.dist_q.size() != 0) @(posedge aclk);
        repeat (1200) @(posedge aclk);
        if (sb.fail_cnt == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
